// ----- rtl/gfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfm_pkg
// Shared types, register indexes and constants of the gated frequency meter.
// ----------------------------------------------------------------------------
package gfm_pkg;

   localparam int GATE_TICKS_DEF  = 10;
   localparam int BLINK_TICKS_DEF = 20;
   localparam int COUNT_BITS_DEF  = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 14;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALARM_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CALIB_OFFSET    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_L1_BLINK_ENABLE = 2'd2;

   localparam logic [13:0] THRESHOLD_RESET = 14'd2000;

   localparam int FREQ_SAT = 1048575;
   localparam int DAC_KNEE = 500;

   localparam logic [7:0] DAC_ZERO = 8'd0;
   localparam logic [7:0] DAC_LOW  = 8'd51;
   localparam logic [7:0] DAC_HIGH = 8'd255;
   localparam logic [7:0] DAC_SPAN = 8'd204;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_MUL10,
      ST_OFFSET,
      ST_DIFF,
      ST_SCALE,
      ST_DEN,
      ST_DIVIDE,
      ST_BIAS,
      ST_LAMPS,
      ST_DONE
   } gfm_state_type;

   typedef struct packed {
      logic [13:0]        alarm_threshold;
      logic signed [10:0] calib_offset;
      logic               l1_blink_enable;
   } gfm_cfg_type;

   typedef struct packed {
      logic [9:0] pulses;
      logic [4:0] hour_now;
      logic [5:0] minute_now;
      logic [5:0] second_now;
   } gfm_item_type;

   typedef struct packed {
      logic signed [20:0] frequency;
      logic [7:0]         dac_code;
      logic               led1_on;
      logic               led2_on;
      logic               below_zero;
      logic [19:0]        peak_freq;
      logic [4:0]         peak_hour;
      logic [5:0]         peak_minute;
      logic [5:0]         peak_second;
   } gfm_result_type;

endpackage

// ----- rtl/gfm_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfm_req_if
// Tick channel: pulse count of one 10 ms tick and the current time.
// ----------------------------------------------------------------------------
interface gfm_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] pulses;
   logic [4:0] hour_now;
   logic [5:0] minute_now;
   logic [5:0] second_now;

   modport source (output valid, pulses, hour_now, minute_now, second_now, input ready);
   modport sink   (input valid, pulses, hour_now, minute_now, second_now, output ready);
endinterface

// ----- rtl/gfm_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfm_rsp_if
// Result channel: frequency, DAC code, lamps and peak record.
// ----------------------------------------------------------------------------
interface gfm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] frequency;
   logic [7:0]         dac_code;
   logic               led1_on;
   logic               led2_on;
   logic               below_zero;
   logic [19:0]        peak_freq;
   logic [4:0]         peak_hour;
   logic [5:0]         peak_minute;
   logic [5:0]         peak_second;

   modport source (output valid, frequency, dac_code, led1_on, led2_on, below_zero,
                   peak_freq, peak_hour, peak_minute, peak_second, input ready);
   modport sink   (input valid, frequency, dac_code, led1_on, led2_on, below_zero,
                   peak_freq, peak_hour, peak_minute, peak_second, output ready);
endinterface

// ----- rtl/gfm_csr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfm_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gfm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [gfm_pkg::CSR_INDEX_BITS-1:0] index;
   logic [gfm_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/gated_frequency_meter_dac_alarm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_frequency_meter_dac_alarm
// Gated frequency meter with DAC code, peak record and two alarm lamps.
// ----------------------------------------------------------------------------
// Each request word is one 10 ms tick; one response word follows per tick.
// Datapath sums run through one shared adder under a sequencer. When the DAC
// code is clamped (negative, at or below 500 Hz, or at or above the
// threshold), the tick skips the linear segment, where the code is built
// by eight shift-add steps and an eight-step restoring division. A
// finished response waits in its own register, so the next tick is taken
// before the response is read; the sequencer then holds at its last step
// until the response register frees.
// Register writes are always accepted and are registered before they take effect.
// ----------------------------------------------------------------------------
module gated_frequency_meter_dac_alarm #(
   parameter int GATE_TICKS  = gfm_pkg::GATE_TICKS_DEF,
   parameter int BLINK_TICKS = gfm_pkg::BLINK_TICKS_DEF,
   parameter int COUNT_BITS  = gfm_pkg::COUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   gfm_req_if.sink     req_ch,
   gfm_rsp_if.source   rsp_ch,
   gfm_csr_if.sink     csr_ch
);

   localparam int AW = (COUNT_BITS + 5 > 24) ? COUNT_BITS + 5 : 24;

   gfm_pkg::gfm_cfg_type    cfg_ff, cfg_in;
   gfm_pkg::gfm_item_type   item;
   gfm_pkg::gfm_result_type result;
   gfm_pkg::gfm_result_type rsp_data_ff;
   logic                    rsp_valid_ff;
   logic                    seq_idle, seq_done, rsp_load;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            gfm_pkg::CSR_ALARM_THRESHOLD: cfg_in.alarm_threshold = csr_ch.data[13:0];
            gfm_pkg::CSR_CALIB_OFFSET:    cfg_in.calib_offset    = $signed(csr_ch.data[10:0]);
            gfm_pkg::CSR_L1_BLINK_ENABLE: cfg_in.l1_blink_enable = csr_ch.data[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_threshold <= gfm_pkg::THRESHOLD_RESET;
         cfg_ff.calib_offset    <= '0;
         cfg_ff.l1_blink_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign item.pulses     = req_ch.pulses;
   assign item.hour_now   = req_ch.hour_now;
   assign item.minute_now = req_ch.minute_now;
   assign item.second_now = req_ch.second_now;
   assign req_ch.ready    = seq_idle;

   assign rsp_load = seq_done && (!rsp_valid_ff || rsp_ch.ready);

   gfm_seq #(
      .GATE_TICKS  (GATE_TICKS),
      .BLINK_TICKS (BLINK_TICKS),
      .COUNT_BITS  (COUNT_BITS),
      .AW          (AW)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (req_ch.valid),
      .item   (item),
      .cfg    (cfg_ff),
      .idle   (seq_idle),
      .done   (seq_done),
      .taken  (rsp_load),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.frequency   = rsp_data_ff.frequency;
   assign rsp_ch.dac_code    = rsp_data_ff.dac_code;
   assign rsp_ch.led1_on     = rsp_data_ff.led1_on;
   assign rsp_ch.led2_on     = rsp_data_ff.led2_on;
   assign rsp_ch.below_zero  = rsp_data_ff.below_zero;
   assign rsp_ch.peak_freq   = rsp_data_ff.peak_freq;
   assign rsp_ch.peak_hour   = rsp_data_ff.peak_hour;
   assign rsp_ch.peak_minute = rsp_data_ff.peak_minute;
   assign rsp_ch.peak_second = rsp_data_ff.peak_second;

endmodule

// ----- rtl/gfm_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfm_alu
// Shared two's complement adder / subtractor used by the sequencer's arithmetic steps.
// ----------------------------------------------------------------------------
module gfm_alu #(
   parameter int W = 24
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         sub,
   output logic [W-1:0] y
);

   assign y = sub ? (a - b) : (a + b);

endmodule

// ----- rtl/gfm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfm_seq
// Sequencer and state of the meter: gate accumulation, calibration, DAC map
// by shift-add scaling and restoring division, peak capture and lamps.
// ----------------------------------------------------------------------------
module gfm_seq #(
   parameter int GATE_TICKS  = gfm_pkg::GATE_TICKS_DEF,
   parameter int BLINK_TICKS = gfm_pkg::BLINK_TICKS_DEF,
   parameter int COUNT_BITS  = gfm_pkg::COUNT_BITS_DEF,
   parameter int AW          = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  gfm_pkg::gfm_item_type   item,
   input  gfm_pkg::gfm_cfg_type    cfg,
   output logic                    idle,
   output logic                    done,
   input  logic                    taken,
   output gfm_pkg::gfm_result_type result
);

   localparam logic [AW-1:0] FREQ_SAT_W = AW'(gfm_pkg::FREQ_SAT);
   localparam logic [AW-1:0] KNEE_W     = AW'(gfm_pkg::DAC_KNEE);

   gfm_pkg::gfm_state_type state_ff, state_in;
   gfm_pkg::gfm_item_type  item_ff, item_in;

   logic [3:0]            tick_ff, tick_in;
   logic [COUNT_BITS-1:0] accum_ff, accum_in;
   logic [COUNT_BITS-1:0] latched_ff, latched_in;
   logic [19:0]           peak_val_ff, peak_val_in;
   logic [4:0]            peak_hh_ff, peak_hh_in;
   logic [5:0]            peak_mm_ff, peak_mm_in;
   logic [5:0]            peak_ss_ff, peak_ss_in;
   logic [4:0]            blink1_ff, blink1_in;
   logic [4:0]            blink2_ff, blink2_in;
   logic                  lamp1_ff, lamp1_in;
   logic                  lamp2_ff, lamp2_in;

   logic [AW-1:0] f_ff, f_in;
   logic [AW-1:0] diff_ff, diff_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [AW-1:0] den_ff, den_in;
   logic [7:0]    quot_ff, quot_in;
   logic [2:0]    step_ff, step_in;
   logic [7:0]    dac_ff, dac_in;

   logic [AW-1:0]         alu_a, alu_b, alu_y;
   logic                  alu_sub;
   logic [COUNT_BITS-1:0] acc_new;
   logic [4:0]            blink_next1, blink_next2;

   gfm_alu #(.W(AW)) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .y   (alu_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= gfm_pkg::ST_IDLE;
         tick_ff     <= '0;
         accum_ff    <= '0;
         latched_ff  <= '0;
         peak_val_ff <= '0;
         peak_hh_ff  <= '0;
         peak_mm_ff  <= '0;
         peak_ss_ff  <= '0;
         blink1_ff   <= '0;
         blink2_ff   <= '0;
         lamp1_ff    <= 1'b0;
         lamp2_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tick_ff     <= tick_in;
         accum_ff    <= accum_in;
         latched_ff  <= latched_in;
         peak_val_ff <= peak_val_in;
         peak_hh_ff  <= peak_hh_in;
         peak_mm_ff  <= peak_mm_in;
         peak_ss_ff  <= peak_ss_in;
         blink1_ff   <= blink1_in;
         blink2_ff   <= blink2_in;
         lamp1_ff    <= lamp1_in;
         lamp2_ff    <= lamp2_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      f_ff    <= f_in;
      diff_ff <= diff_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      dac_ff  <= dac_in;
   end

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      tick_in     = tick_ff;
      accum_in    = accum_ff;
      latched_in  = latched_ff;
      peak_val_in = peak_val_ff;
      peak_hh_in  = peak_hh_ff;
      peak_mm_in  = peak_mm_ff;
      peak_ss_in  = peak_ss_ff;
      blink1_in   = blink1_ff;
      blink2_in   = blink2_ff;
      lamp1_in    = lamp1_ff;
      lamp2_in    = lamp2_ff;
      f_in        = f_ff;
      diff_in     = diff_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      quot_in     = quot_ff;
      step_in     = step_ff;
      dac_in      = dac_ff;
      alu_a       = '0;
      alu_b       = '0;
      alu_sub     = 1'b0;
      acc_new     = '0;
      blink_next1 = blink1_ff + 5'd1;
      blink_next2 = blink2_ff + 5'd1;
      idle        = 1'b0;
      done        = 1'b0;

      unique case (state_ff)
         gfm_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               item_in  = item;
               state_in = gfm_pkg::ST_ACCUM;
            end
         end
         gfm_pkg::ST_ACCUM: begin
            alu_a   = AW'(accum_ff);
            alu_b   = AW'(item_ff.pulses);
            acc_new = (|alu_y[AW-1:COUNT_BITS]) ? '1 : alu_y[COUNT_BITS-1:0];
            if (({1'b0, tick_ff} + 5'd1) >= 5'(GATE_TICKS)) begin
               tick_in    = '0;
               latched_in = acc_new;
               accum_in   = '0;
            end else begin
               tick_in  = tick_ff + 4'd1;
               accum_in = acc_new;
            end
            state_in = gfm_pkg::ST_MUL10;
         end
         gfm_pkg::ST_MUL10: begin
            // times ten as eight plus two
            alu_a    = AW'(latched_ff) << 3;
            alu_b    = AW'(latched_ff) << 1;
            f_in     = alu_y;
            state_in = gfm_pkg::ST_OFFSET;
         end
         gfm_pkg::ST_OFFSET: begin
            alu_a    = f_ff;
            alu_b    = AW'(cfg.calib_offset);
            f_in     = ($signed(alu_y) > $signed(FREQ_SAT_W)) ? FREQ_SAT_W : alu_y;
            state_in = gfm_pkg::ST_DIFF;
         end
         gfm_pkg::ST_DIFF: begin
            alu_a   = f_ff;
            alu_b   = KNEE_W;
            alu_sub = 1'b1;
            diff_in = alu_y;
            rem_in  = '0;
            step_in = 3'd7;
            priority if (f_ff[AW-1]) begin
               dac_in   = gfm_pkg::DAC_ZERO;
               state_in = gfm_pkg::ST_LAMPS;
            end else if ($signed(f_ff) <= $signed(KNEE_W)) begin
               dac_in   = gfm_pkg::DAC_LOW;
               state_in = gfm_pkg::ST_LAMPS;
            end else if ($signed(f_ff) >= $signed(AW'(cfg.alarm_threshold))) begin
               dac_in   = gfm_pkg::DAC_HIGH;
               state_in = gfm_pkg::ST_LAMPS;
            end else begin
               state_in = gfm_pkg::ST_SCALE;
            end
         end
         gfm_pkg::ST_SCALE: begin
            alu_a  = rem_ff;
            alu_b  = gfm_pkg::DAC_SPAN[step_ff] ? (diff_ff << step_ff) : '0;
            rem_in = alu_y;
            if (step_ff == 3'd0) begin
               state_in = gfm_pkg::ST_DEN;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         gfm_pkg::ST_DEN: begin
            alu_a    = AW'(cfg.alarm_threshold);
            alu_b    = KNEE_W;
            alu_sub  = 1'b1;
            den_in   = alu_y;
            step_in  = 3'd7;
            quot_in  = '0;
            state_in = gfm_pkg::ST_DIVIDE;
         end
         gfm_pkg::ST_DIVIDE: begin
            alu_a   = rem_ff;
            alu_b   = den_ff << step_ff;
            alu_sub = 1'b1;
            if (!alu_y[AW-1]) begin
               rem_in           = alu_y;
               quot_in[step_ff] = 1'b1;
            end
            if (step_ff == 3'd0) begin
               state_in = gfm_pkg::ST_BIAS;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         gfm_pkg::ST_BIAS: begin
            alu_a    = AW'(quot_ff);
            alu_b    = AW'(gfm_pkg::DAC_LOW);
            dac_in   = alu_y[7:0];
            state_in = gfm_pkg::ST_LAMPS;
         end
         gfm_pkg::ST_LAMPS: begin
            alu_a   = AW'(peak_val_ff);
            alu_b   = f_ff;
            alu_sub = 1'b1;
            if (alu_y[AW-1]) begin
               peak_val_in = f_ff[19:0];
               peak_hh_in  = item_ff.hour_now;
               peak_mm_in  = item_ff.minute_now;
               peak_ss_in  = item_ff.second_now;
            end
            if (cfg.l1_blink_enable) begin
               if (blink_next1 >= 5'(BLINK_TICKS)) begin
                  blink1_in = '0;
                  lamp1_in  = !lamp1_ff;
               end else begin
                  blink1_in = blink_next1;
               end
            end else begin
               blink1_in = '0;
               lamp1_in  = 1'b0;
            end
            priority if ($signed(f_ff) > $signed(AW'(cfg.alarm_threshold))) begin
               if (blink_next2 >= 5'(BLINK_TICKS)) begin
                  blink2_in = '0;
                  lamp2_in  = !lamp2_ff;
               end else begin
                  blink2_in = blink_next2;
               end
            end else if (f_ff[AW-1]) begin
               blink2_in = '0;
               lamp2_in  = 1'b1;
            end else begin
               blink2_in = '0;
               lamp2_in  = 1'b0;
            end
            state_in = gfm_pkg::ST_DONE;
         end
         gfm_pkg::ST_DONE: begin
            done = 1'b1;
            if (taken) begin
               state_in = gfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gfm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      result.frequency   = $signed(f_ff[20:0]);
      result.dac_code    = dac_ff;
      result.led1_on     = lamp1_ff;
      result.led2_on     = lamp2_ff;
      result.below_zero  = f_ff[AW-1];
      result.peak_freq   = peak_val_ff;
      result.peak_hour   = peak_hh_ff;
      result.peak_minute = peak_mm_ff;
      result.peak_second = peak_ss_ff;
   end

endmodule
